### design/stepper_position_command_controller_top_defines.svh
// assertion macros for the stepper position command controller checker
// no dependencies; included by the checker file only
`ifndef STEPPER_POSITION_COMMAND_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_POSITION_COMMAND_CONTROLLER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SPCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SPCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/spcc_pkg.sv
// shared types, constants and drive tables of the stepper position command controller
// no dependencies
package spcc_pkg;

    localparam int unsigned POS_W = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    // command codes (ascii)
    localparam logic [7:0] CMD_NONE   = 8'h00;
    localparam logic [7:0] CMD_UP     = 8'h55;
    localparam logic [7:0] CMD_DOWN   = 8'h44;
    localparam logic [7:0] CMD_OPEN   = 8'h4F;
    localparam logic [7:0] CMD_CLOSE  = 8'h43;
    localparam logic [7:0] CMD_HOME   = 8'h50;
    localparam logic [7:0] CMD_FLOOR1 = 8'h31;
    localparam logic [7:0] CMD_FLOOR2 = 8'h32;
    localparam logic [7:0] CMD_FLOOR3 = 8'h33;
    localparam logic [7:0] CMD_FLOOR4 = 8'h34;
    localparam logic [7:0] CMD_REPORT = 8'h21;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_ONE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_TWO   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_THREE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOOR_FOUR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HOME        = 3'd4;

    // reset values
    localparam logic [POS_W-1:0] FLOOR_ONE_RESET   = 16'd31093;
    localparam logic [POS_W-1:0] FLOOR_TWO_RESET   = 16'd31654;
    localparam logic [POS_W-1:0] FLOOR_THREE_RESET = 16'd32209;
    localparam logic [POS_W-1:0] FLOOR_FOUR_RESET  = 16'd32767;
    localparam logic [POS_W-1:0] HOME_RESET        = 16'd32767;
    localparam logic [POS_W-1:0] POSITION_RESET    = 16'd32767;

    typedef struct packed {
        logic       command_valid;
        logic [7:0] command_byte;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0]       drive_pattern;
        logic [POS_W-1:0] cabin_position;
        logic             report;
    } result_word_t;

    typedef struct packed {
        logic [POS_W-1:0] floor_one_target;
        logic [POS_W-1:0] floor_two_target;
        logic [POS_W-1:0] floor_three_target;
        logic [POS_W-1:0] floor_four_target;
        logic [POS_W-1:0] home_position;
    } cfg_regs_t;

    typedef struct packed {
        logic [7:0]       held_command;
        logic [1:0]       door_phase;
        logic [1:0]       cabin_phase;
        logic [POS_W-1:0] position_count;
        logic [7:0]       drive_latch;
    } step_state_t;

    // cabin full-step phase pattern
    function automatic logic [3:0] full_phase(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'b1010;
            2'd1:    pat = 4'b0110;
            2'd2:    pat = 4'b0101;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

    // door wave-drive phase pattern
    function automatic logic [3:0] wave_phase(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'b1000;
            2'd1:    pat = 4'b0100;
            2'd2:    pat = 4'b0010;
            default: pat = 4'b0001;
        endcase
        return pat;
    endfunction

endpackage

### design/spcc_cfg_regs.sv
// floor target and home position registers with write decode
// depends on spcc_pkg
module spcc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [spcc_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [spcc_pkg::POS_W-1:0]          wr_data,
    output spcc_pkg::cfg_regs_t                 regs
);
    import spcc_pkg::*;

    cfg_regs_t regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.floor_one_target   <= FLOOR_ONE_RESET;
            regs_reg.floor_two_target   <= FLOOR_TWO_RESET;
            regs_reg.floor_three_target <= FLOOR_THREE_RESET;
            regs_reg.floor_four_target  <= FLOOR_FOUR_RESET;
            regs_reg.home_position      <= HOME_RESET;
        end
        else if (wr_en)
        begin
            // indexes past the last register are dropped
            case (wr_index)
                REG_FLOOR_ONE:   regs_reg.floor_one_target   <= wr_data;
                REG_FLOOR_TWO:   regs_reg.floor_two_target   <= wr_data;
                REG_FLOOR_THREE: regs_reg.floor_three_target <= wr_data;
                REG_FLOOR_FOUR:  regs_reg.floor_four_target  <= wr_data;
                REG_HOME:        regs_reg.home_position      <= wr_data;
                default:         ;
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

### design/spcc_step_logic.sv
// one tick of command decode, stepping, seek compare and report
// depends on spcc_pkg
module spcc_step_logic (
    input  spcc_pkg::step_state_t   state,
    input  spcc_pkg::cmd_word_t     cmd_word,
    input  spcc_pkg::cfg_regs_t     cfg,
    output spcc_pkg::step_state_t   state_next,
    output spcc_pkg::result_word_t  result
);
    import spcc_pkg::*;

    logic [7:0]       cmd;
    logic             cabin_step;
    logic             cabin_dir;
    logic             door_step;
    logic             door_dir;
    logic             seek_en;
    logic [POS_W-1:0] goal;
    logic             report;
    step_state_t      nxt;

    assign cmd = cmd_word.command_valid ? cmd_word.command_byte : state.held_command;

    always_comb
    begin
        nxt              = state;
        nxt.held_command = cmd;
        cabin_step       = 1'b0;
        cabin_dir        = 1'b0;
        door_step        = 1'b0;
        door_dir         = 1'b0;
        seek_en          = 1'b0;
        goal             = cfg.floor_one_target;
        report           = 1'b0;

        case (cmd)
            CMD_UP:
            begin
                cabin_step = 1'b1;
                cabin_dir  = 1'b1;
            end
            CMD_DOWN:   cabin_step = 1'b1;
            CMD_OPEN:
            begin
                door_step = 1'b1;
                door_dir  = 1'b1;
            end
            CMD_CLOSE:  door_step = 1'b1;
            CMD_HOME:   nxt.position_count = cfg.home_position;
            CMD_FLOOR1: seek_en = 1'b1;
            CMD_FLOOR2:
            begin
                seek_en = 1'b1;
                goal    = cfg.floor_two_target;
            end
            CMD_FLOOR3:
            begin
                seek_en = 1'b1;
                goal    = cfg.floor_three_target;
            end
            CMD_FLOOR4:
            begin
                seek_en = 1'b1;
                goal    = cfg.floor_four_target;
            end
            CMD_REPORT: report = 1'b1;
            default:    ;
        endcase

        // arrival turns the floor command into a report in the same tick
        if (seek_en)
        begin
            if (goal != state.position_count)
            begin
                cabin_step = 1'b1;
                cabin_dir  = goal > state.position_count;
            end
            else
            begin
                report = 1'b1;
            end
        end

        if (cabin_step)
        begin
            if (cabin_dir)
            begin
                nxt.cabin_phase    = state.cabin_phase + 2'd1;
                nxt.position_count = state.position_count + 16'd1;
            end
            else
            begin
                nxt.cabin_phase    = state.cabin_phase - 2'd1;
                nxt.position_count = state.position_count - 16'd1;
            end
        end

        if (door_step)
        begin
            nxt.door_phase = door_dir ? (state.door_phase + 2'd1)
                                      : (state.door_phase - 2'd1);
        end

        if (cabin_step || door_step)
        begin
            nxt.drive_latch = {full_phase(nxt.cabin_phase), wave_phase(nxt.door_phase)};
        end

        if (report)
        begin
            nxt.held_command = CMD_NONE;
        end
    end

    assign state_next            = nxt;
    assign result.drive_pattern  = nxt.drive_latch;
    assign result.cabin_position = nxt.position_count;
    assign result.report         = report;

endmodule

### design/stepper_position_command_controller_top.sv
// top level of the stepper position command controller: input register, step state, result register
// depends on spcc_pkg, spcc_cfg_regs, spcc_step_logic
//
//  channel | direction | handshake              | word
//  in      | to block  | in_valid / in_stall    | command_valid, command_byte
//  out     | from      | out_valid / out_stall  | drive_pattern, cabin_position, report
//  cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one word per cycle while out is not stalled; an accepted word is held in the input register,
// then in the result register, from which out presents it until it is taken
// the step decode is combinational between the input register and the result register
// reset clears the held command, phases and drive, loads position 32767 and the default targets
// a stalled result holds the input register, which then raises in_stall; cfg_ready is always high
module stepper_position_command_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  spcc_pkg::cmd_word_t               in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output spcc_pkg::result_word_t            out_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [spcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spcc_pkg::POS_W-1:0]        cfg_data
);
    import spcc_pkg::*;

    logic         in_valid_reg;
    cmd_word_t    in_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;
    step_state_t  state_reg;
    step_state_t  state_next;
    result_word_t result;
    cfg_regs_t    cfg;
    logic         advance;

    assign cfg_ready = 1'b1;

    spcc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (cfg)
    );

    spcc_step_logic u_step (
        .state      (state_reg),
        .cmd_word   (in_word_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result)
    );

    // the step commits only when the result register can take its word
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_word_reg <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.held_command   <= CMD_NONE;
            state_reg.door_phase     <= 2'd0;
            state_reg.cabin_phase    <= 2'd0;
            state_reg.position_count <= POSITION_RESET;
            state_reg.drive_latch    <= 8'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### design/spcc_checker.sv
// port-level checks of the stepper position command controller, bound to the top level
// depends on spcc_pkg and stepper_position_command_controller_top_defines.svh
`include "stepper_position_command_controller_top_defines.svh"

module spcc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  spcc_pkg::cmd_word_t               in_word,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  spcc_pkg::result_word_t            out_word,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [spcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spcc_pkg::POS_W-1:0]        cfg_data
);
    import spcc_pkg::*;

    logic [3:0] cabin_nib;
    logic [3:0] door_nib;
    logic       drive_ok;
    logic       unused_ok;

    assign cabin_nib = out_word.drive_pattern[7:4];
    assign door_nib  = out_word.drive_pattern[3:0];

    // drive is either all off or a legal full-step / wave pair
    assign drive_ok = (out_word.drive_pattern == 8'd0)
                   || ($onehot(door_nib)
                       && ((cabin_nib == full_phase(2'd0)) || (cabin_nib == full_phase(2'd1))
                        || (cabin_nib == full_phase(2'd2)) || (cabin_nib == full_phase(2'd3))));

    assign unused_ok = ^{in_word, cfg_valid, cfg_ready, cfg_index, cfg_data};

    `SPCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")
    `SPCC_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")
    `SPCC_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && !in_stall, ##1 out_valid, "accepted word did not reach the output")
    `SPCC_ASSERT_NOW(a_drive_legal, clk, rst_n, out_valid && (unused_ok || !unused_ok), drive_ok, "illegal drive pattern")

endmodule

bind stepper_position_command_controller_top spcc_checker u_spcc_checker (.*);
